// File: hw/rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

  // Configuration register indexes
  typedef enum logic {
    CFG_MIN_LENGTH = 1'b0,
    CFG_BYTE_LIMIT = 1'b1
  } cfg_reg_e;

  localparam logic [4:0]  MIN_LENGTH_RST = 5'd4;
  localparam logic [31:0] BYTE_LIMIT_RST = 32'd10485760;

  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_NL  = 8'h0A;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  // Truncation message
  localparam int MSG_LEN   = 34;
  localparam int MSG_IDX_W = 6;
  localparam logic [7:0] MSG_ROM [MSG_LEN] = '{
    8'h0A, "[", "T", "r", "u", "n", "c", "a", "t", "e", "d", " ", "-", " ",
    "S", "i", "z", "e", " ", "l", "i", "m", "i", "t", " ",
    "r", "e", "a", "c", "h", "e", "d", "]", 8'h0A
  };

  // Commands from the classifier to the emitter
  typedef enum logic [1:0] {
    CMD_BYTE    = 2'd0,  // one byte, last of its transaction
    CMD_RELEASE = 2'd1,  // replay held run, data holds the byte count
    CMD_NLMSG   = 2'd2   // newline followed by truncation message
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] data;
  } cmd_t;

  // Emitter states
  typedef enum logic [1:0] {
    BK_IDLE    = 2'd0,
    BK_REL_RD  = 2'd1,
    BK_REL_OUT = 2'd2,
    BK_MSG     = 2'd3
  } back_state_e;

  // Saturating 32-bit add
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pse_if.sv
`default_nettype none

// Raw byte channel
interface pse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, output data_byte, output end_marker, input ready);
  modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

// Extracted text channel
interface pse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_message;
  logic       last_of_burst;

  modport source (output valid, output out_byte, output is_message, output last_of_burst,
                  input ready);
  modport sink   (input valid, input out_byte, input is_message, input last_of_burst,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pse_ram.sv
`default_nettype none

module pse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/pse_cmd_fifo.sv
`default_nettype none

module pse_cmd_fifo #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  pse_pkg::cmd_t      cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output pse_pkg::cmd_t      cmd_o
);

  pse_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into full queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PW+1)'(DEPTH))
    else $error("queue level beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// File: hw/rtl/pse_front.sv
`default_nettype none

module pse_front #(
  parameter int MAX_MIN_RUN = 16,
  localparam int CW = $clog2(MAX_MIN_RUN + 1),
  localparam int AW = (MAX_MIN_RUN > 1) ? $clog2(MAX_MIN_RUN) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pse_in_if.sink           in_ch,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        fifo_full_i,
  output logic             push_o,
  output pse_pkg::cmd_t    cmd_o,
  input  wire logic        rel_done_i,
  output logic             ram_we_o,
  output logic [AW-1:0]    ram_waddr_o,
  output logic [7:0]       ram_wdata_o
);

  logic [4:0]    min_len_q;
  logic [31:0]   limit_q;
  logic [CW-1:0] run_count_q, run_count_d;
  logic          passing_q, passing_d;
  logic [31:0]   emitted_q, emitted_d;
  logic          stopped_q, stopped_d;
  logic          rel_pend_q, rel_pend_d;

  logic          accept, printable;
  logic [CW-1:0] eff_min, grown;
  logic [31:0]   emit_plus1, emit_plus_n;
  logic [7:0]    b;

  assign b         = in_ch.data_byte;
  assign in_ch.ready = !fifo_full_i && !rel_pend_q;
  assign accept    = in_ch.valid && in_ch.ready;
  assign printable = (b >= pse_pkg::PRINT_LO && b <= pse_pkg::PRINT_HI)
                     || b == pse_pkg::CHAR_TAB || b == pse_pkg::CHAR_NL;

  // Clamp minimum run length into 1..MAX_MIN_RUN
  always_comb begin
    if (min_len_q == '0) begin
      eff_min = CW'(1);
    end else if (32'(min_len_q) > 32'(MAX_MIN_RUN)) begin
      eff_min = CW'(MAX_MIN_RUN);
    end else begin
      eff_min = CW'(min_len_q);
    end
  end

  // Held run length after storing this byte (capped at buffer size)
  assign grown = (32'(run_count_q) < 32'(MAX_MIN_RUN)) ? run_count_q + 1'b1 : run_count_q;

  assign emit_plus1  = pse_pkg::sat_add(emitted_q, 32'd1);
  assign emit_plus_n = pse_pkg::sat_add(emitted_q, 32'(grown));

  assign ram_waddr_o = run_count_q[AW-1:0];
  assign ram_wdata_o = b;

  // Classification and run tracking
  always_comb begin
    run_count_d = run_count_q;
    passing_d   = passing_q;
    emitted_d   = emitted_q;
    stopped_d   = stopped_q;
    rel_pend_d  = rel_pend_q && !rel_done_i;
    push_o      = 1'b0;
    cmd_o.op    = pse_pkg::CMD_BYTE;
    cmd_o.data  = b;
    ram_we_o    = 1'b0;

    if (accept && !stopped_q) begin
      if (in_ch.end_marker) begin
        // flush: close a forwarded run with a newline
        if (passing_q) begin
          push_o     = 1'b1;
          cmd_o.data = pse_pkg::CHAR_NL;
          emitted_d  = emit_plus1;
        end
        run_count_d = '0;
        passing_d   = 1'b0;
      end else if (printable) begin
        if (passing_q) begin
          push_o    = 1'b1;
          emitted_d = emit_plus1;
        end else begin
          ram_we_o = (32'(run_count_q) < 32'(MAX_MIN_RUN));
          if (grown >= eff_min) begin
            push_o      = 1'b1;
            cmd_o.op    = pse_pkg::CMD_RELEASE;
            cmd_o.data  = 8'(grown);
            emitted_d   = emit_plus_n;
            run_count_d = '0;
            passing_d   = 1'b1;
            rel_pend_d  = 1'b1;
          end else begin
            run_count_d = grown;
          end
        end
      end else begin
        // terminator: newline, then limit check
        if (passing_q) begin
          push_o    = 1'b1;
          emitted_d = emit_plus1;
          if (emit_plus1 >= limit_q) begin
            cmd_o.op  = pse_pkg::CMD_NLMSG;
            stopped_d = 1'b1;
          end else begin
            cmd_o.data = pse_pkg::CHAR_NL;
          end
        end
        run_count_d = '0;
        passing_d   = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_count_q <= '0;
      passing_q   <= 1'b0;
      emitted_q   <= '0;
      stopped_q   <= 1'b0;
      rel_pend_q  <= 1'b0;
    end else begin
      run_count_q <= run_count_d;
      passing_q   <= passing_d;
      emitted_q   <= emitted_d;
      stopped_q   <= stopped_d;
      rel_pend_q  <= rel_pend_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= pse_pkg::MIN_LENGTH_RST;
      limit_q   <= pse_pkg::BYTE_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (pse_pkg::cfg_reg_e'(cfg_idx_i))
        pse_pkg::CFG_MIN_LENGTH: min_len_q <= cfg_data_i[4:0];
        pse_pkg::CFG_BYTE_LIMIT: limit_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  a_stopped_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |=> stopped_q)
    else $error("stopped flag cleared without reset");

  a_passing_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    passing_q |-> run_count_q == '0)
    else $error("bytes held while run is forwarded");

  a_no_write_in_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_pend_q |-> !ram_we_o)
    else $error("held run overwritten during replay");

endmodule

`default_nettype wire

// File: hw/rtl/pse_back.sv
`default_nettype none

module pse_back #(
  parameter int MAX_MIN_RUN = 16,
  localparam int CW = $clog2(MAX_MIN_RUN + 1),
  localparam int AW = (MAX_MIN_RUN > 1) ? $clog2(MAX_MIN_RUN) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cmd_valid_i,
  input  pse_pkg::cmd_t    cmd_i,
  output logic             pop_o,
  output logic             rel_done_o,
  output logic [AW-1:0]    ram_raddr_o,
  input  wire logic [7:0]  ram_rdata_i,
  pse_out_if.source        out_ch
);

  pse_pkg::back_state_e state_q, state_d;
  logic [CW-1:0]                 idx_q, idx_d, cnt_q, cnt_d;
  logic [pse_pkg::MSG_IDX_W-1:0] msg_q, msg_d;

  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_msg_q, out_last_q;

  logic       slot_free, load, ld_msg, ld_last;
  logic [7:0] ld_byte;

  assign slot_free   = !out_valid_q || out_ch.ready;
  assign ram_raddr_o = idx_q[AW-1:0];

  // Command sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    msg_d      = msg_q;
    pop_o      = 1'b0;
    rel_done_o = 1'b0;
    load       = 1'b0;
    ld_byte    = cmd_i.data;
    ld_msg     = 1'b0;
    ld_last    = 1'b0;

    case (state_q)
      pse_pkg::BK_IDLE: begin
        if (cmd_valid_i && slot_free) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            pse_pkg::CMD_BYTE: begin
              load    = 1'b1;
              ld_last = 1'b1;
            end
            pse_pkg::CMD_RELEASE: begin
              idx_d   = '0;
              cnt_d   = CW'(cmd_i.data);
              state_d = pse_pkg::BK_REL_RD;
            end
            pse_pkg::CMD_NLMSG: begin
              load    = 1'b1;
              ld_byte = pse_pkg::CHAR_NL;
              msg_d   = '0;
              state_d = pse_pkg::BK_MSG;
            end
            default: ;
          endcase
        end
      end
      pse_pkg::BK_REL_RD: begin
        // address settles, data registered next cycle
        state_d = pse_pkg::BK_REL_OUT;
      end
      pse_pkg::BK_REL_OUT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_byte = ram_rdata_i;
          ld_last = (idx_q == CW'(cnt_q - 1'b1));
          if (ld_last) begin
            rel_done_o = 1'b1;
            state_d    = pse_pkg::BK_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = pse_pkg::BK_REL_RD;
          end
        end
      end
      pse_pkg::BK_MSG: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_byte = pse_pkg::MSG_ROM[msg_q];
          ld_msg  = 1'b1;
          ld_last = (msg_q == pse_pkg::MSG_IDX_W'(pse_pkg::MSG_LEN - 1));
          if (ld_last) begin
            state_d = pse_pkg::BK_IDLE;
          end else begin
            msg_d = msg_q + 1'b1;
          end
        end
      end
      default: state_d = pse_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::BK_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      msg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      msg_q   <= msg_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= ld_byte;
      out_msg_q  <= ld_msg;
      out_last_q <= ld_last;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.out_byte      = out_byte_q;
  assign out_ch.is_message    = out_msg_q;
  assign out_ch.last_of_burst = out_last_q;

  a_done_in_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_done_o |-> state_q == pse_pkg::BK_REL_OUT)
    else $error("replay done outside replay");

  a_read_before_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pse_pkg::BK_REL_OUT |->
      $past(state_q) == pse_pkg::BK_REL_RD || $past(state_q) == pse_pkg::BK_REL_OUT)
    else $error("held byte used without read cycle");

  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> slot_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/printable_string_extractor_top.sv
`default_nettype none

// Channel   Dir  Payload                                  Transaction
// in_ch     in   data_byte[7:0], end_marker               valid && ready
// out_ch    out  out_byte[7:0], is_message, last_of_burst valid && ready
// cfg       in   cfg_idx_i, cfg_data_i[31:0]              cfg_we_i
//
// One raw byte per cycle when no replay is pending and the command queue is not full.
// A qualifying run is replayed from the held-byte RAM via read and output states per byte
// (registered RAM read); truncation message: one byte per cycle if out_ch ready, 35 results.
// in_ch.ready drops while a replay is queued or running, or while the command queue is full.
// Async active-low reset clears all control state; held bytes are not cleared.
// out_ch is registered; downstream stalls fill the command queue, then in_ch.ready drops.

module printable_string_extractor_top #(
  parameter int MAX_MIN_RUN = 16,
  parameter int CMD_DEPTH   = 4,
  localparam int AW = (MAX_MIN_RUN > 1) ? $clog2(MAX_MIN_RUN) : 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pse_in_if.sink           in_ch,
  pse_out_if.source        out_ch,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);

  pse_pkg::cmd_t push_cmd, pop_cmd;
  logic          push, pop, fifo_full, fifo_valid, rel_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Classifier
  pse_front #(
    .MAX_MIN_RUN (MAX_MIN_RUN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .rel_done_i  (rel_done),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Held run bytes
  pse_ram #(
    .WIDTH (8),
    .DEPTH (MAX_MIN_RUN)
  ) u_held_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Command queue
  pse_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .cmd_o   (pop_cmd)
  );

  // Emitter
  pse_back #(
    .MAX_MIN_RUN (MAX_MIN_RUN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (fifo_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .rel_done_o  (rel_done),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire
